// ----- rtl/kcb_pkg.sv -----
// Shared types, constants and helpers for the canonical k-mer stream bucketer.
`default_nettype none
package kcb_pkg;

    localparam int CHAR_W = 8;
    localparam int KMER_W = 62;
    localparam int IDX_W  = 7;
    localparam int K_W    = 5;
    localparam int RUN_W  = 5;

    localparam logic [K_W-1:0]   K_RESET = 5'd31;
    localparam logic [RUN_W-1:0] RUN_MAX = 5'd31;

    localparam int DEF_BUCKET_COUNT = 128;
    localparam int DEF_QUEUE_DEPTH  = 4;

    // splitmix64 finalizer multipliers
    localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;

    // character codes
    localparam logic [CHAR_W-1:0] CH_A_UP = 8'h41;
    localparam logic [CHAR_W-1:0] CH_C_UP = 8'h43;
    localparam logic [CHAR_W-1:0] CH_G_UP = 8'h47;
    localparam logic [CHAR_W-1:0] CH_T_UP = 8'h54;
    localparam logic [CHAR_W-1:0] CH_A_LO = 8'h61;
    localparam logic [CHAR_W-1:0] CH_C_LO = 8'h63;
    localparam logic [CHAR_W-1:0] CH_G_LO = 8'h67;
    localparam logic [CHAR_W-1:0] CH_T_LO = 8'h74;

    localparam logic [1:0] BASE_A = 2'd0;
    localparam logic [1:0] BASE_C = 2'd1;
    localparam logic [1:0] BASE_G = 2'd2;
    localparam logic [1:0] BASE_T = 2'd3;

    typedef struct packed {
        logic       valid;
        logic [1:0] code;
    } base_code_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

    typedef enum logic [3:0] {
        HS_IDLE,
        HS_MUL0,
        HS_MUL1,
        HS_MUL2,
        HS_FOLD0,
        HS_FOLD1,
        HS_RECIP,
        HS_MOD,
        HS_DONE
    } hash_state_t;

    // Map a character byte to its 2-bit base code
    function automatic base_code_t encode_base(input logic [CHAR_W-1:0] ch);
        base_code_t r;
        r.valid = 1'b1;
        r.code  = BASE_A;
        case (ch)
            CH_A_UP, CH_A_LO: r.code = BASE_A;
            CH_C_UP, CH_C_LO: r.code = BASE_C;
            CH_G_UP, CH_G_LO: r.code = BASE_G;
            CH_T_UP, CH_T_LO: r.code = BASE_T;
            default: r.valid = 1'b0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/kcb_front.sv -----
// Front end: base encoding, rolling forward/reverse-complement windows, canonical pick.
`default_nettype none
module kcb_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [kcb_pkg::CHAR_W-1:0]    s_base_char,
    input  wire logic                          s_record_start,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [kcb_pkg::K_W-1:0]       cfg_kmer_length,
    input  wire kcb_pkg::queue_status_t        q_status,
    output logic                               q_push,
    output logic [kcb_pkg::KMER_W-1:0]         q_wdata
);
    import kcb_pkg::*;

    logic [K_W-1:0]    k_reg, k_next;
    logic [KMER_W-1:0] fwd_reg, fwd_next;
    logic [KMER_W-1:0] rev_reg, rev_next;
    logic [RUN_W-1:0]  run_reg, run_next;

    logic              accept;
    base_code_t        bc;
    logic [K_W-1:0]    k_eff;
    logic [KMER_W-1:0] kmask;
    logic [5:0]        ins_shift;
    logic [KMER_W-1:0] fwd_base, rev_base;
    logic [RUN_W-1:0]  run_base, run_inc;
    logic [KMER_W-1:0] fwd_roll, rev_roll;

    // Hold off character beats while a length write lands
    assign s_ready   = !q_status.full && !cfg_valid;
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;

    // Window geometry from the configured length; zero length acts as one base
    assign k_eff     = (k_reg == '0) ? K_W'(1) : k_reg;
    assign kmask     = ~({KMER_W{1'b1}} << {k_eff, 1'b0});
    assign ins_shift = {k_eff - K_W'(1), 1'b0};

    // Roll one base into both windows
    always_comb begin
        bc       = encode_base(s_base_char);
        fwd_base = s_record_start ? '0 : fwd_reg;
        rev_base = s_record_start ? '0 : rev_reg;
        run_base = s_record_start ? '0 : run_reg;
        run_inc  = (run_base == RUN_MAX) ? run_base : run_base + RUN_W'(1);
        fwd_roll = ((fwd_base << 2) | {{(KMER_W-2){1'b0}}, bc.code}) & kmask;
        rev_roll = (rev_base >> 2) | ({{(KMER_W-2){1'b0}}, ~bc.code} << ins_shift);
    end

    // Next state: config write clears, invalid base clears, valid base rolls
    always_comb begin
        k_next   = k_reg;
        fwd_next = fwd_reg;
        rev_next = rev_reg;
        run_next = run_reg;
        q_push   = 1'b0;
        if (cfg_valid && cfg_ready) begin
            k_next   = cfg_kmer_length;
            fwd_next = '0;
            rev_next = '0;
            run_next = '0;
        end else if (accept) begin
            if (bc.valid) begin
                fwd_next = fwd_roll;
                rev_next = rev_roll;
                run_next = run_inc;
                q_push   = (run_inc >= k_eff);
            end else begin
                fwd_next = '0;
                rev_next = '0;
                run_next = '0;
            end
        end
    end

    assign q_wdata = (fwd_roll < rev_roll) ? fwd_roll : rev_roll;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg   <= K_RESET;
            fwd_reg <= '0;
            rev_reg <= '0;
            run_reg <= '0;
        end else begin
            k_reg   <= k_next;
            fwd_reg <= fwd_next;
            rev_reg <= rev_next;
            run_reg <= run_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/kcb_queue.sv -----
// Short register queue of canonical k-mers between front and hash back end.
`default_nettype none
module kcb_queue #(
    parameter int DEPTH = kcb_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          q_push,
    input  wire logic [kcb_pkg::KMER_W-1:0]    q_wdata,
    input  wire logic                          q_pop,
    output logic [kcb_pkg::KMER_W-1:0]         q_rdata,
    output kcb_pkg::queue_status_t             q_status
);
    import kcb_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [KMER_W-1:0] entry_reg [DEPTH];
    logic [AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [AW:0]       count_reg, count_next;
    logic              do_push, do_pop;

    assign q_status.empty = (count_reg == '0);
    assign q_status.full  = (count_reg == (AW+1)'(DEPTH));
    assign do_push        = q_push && !q_status.full;
    assign do_pop         = q_pop && !q_status.empty;
    assign q_rdata        = entry_reg[rd_ptr_reg];

    // Advance pointers with wrap at the queue depth
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH-1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH-1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + (AW+1)'(1);
            2'b01:   count_next = count_reg - (AW+1)'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries; no reset on payload
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= q_wdata;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/kcb_hash.sv -----
// Back end: shared 32x32 multiplier runs the splitmix64 finalizer, then bucket remainder.
`default_nettype none
module kcb_hash #(
    parameter int BUCKET_COUNT = kcb_pkg::DEF_BUCKET_COUNT
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire kcb_pkg::queue_status_t        q_status,
    input  wire logic [kcb_pkg::KMER_W-1:0]    q_rdata,
    output logic                               q_pop,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [kcb_pkg::KMER_W-1:0]         m_canonical_kmer,
    output logic [kcb_pkg::IDX_W-1:0]          m_bucket_index
);
    import kcb_pkg::*;

    localparam int BUCKETS   = (BUCKET_COUNT < 1) ? 1 : BUCKET_COUNT;
    localparam int RW        = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam bit IS_POW2   = ((BUCKETS & (BUCKETS - 1)) == 0);

    localparam logic [RW-1:0] LOW_MASK = RW'(BUCKETS - 1);

    // Remainder for other bucket counts (up to 128, the 7-bit index range): fold 16-bit
    // slices by their residues twice, then divide the small value by a reciprocal multiply
    localparam logic [63:0] B64  = 64'(BUCKETS);
    localparam logic [63:0] R16  = (64'd1 << 16) % B64;
    localparam logic [63:0] R32  = (64'd1 << 32) % B64;
    localparam logic [63:0] R48  = (64'd1 << 48) % B64;
    localparam int          FW   = RW + 18;
    localparam int          ZW   = ((2 * RW + 2 > 16) ? 2 * RW + 2 : 16) + 1;
    localparam int          SH   = ZW + RW;
    localparam int          MW   = ZW + 2;
    localparam int          QW   = ZW + MW - SH;
    localparam logic [MW-1:0] RECIP_M = MW'(((64'd1 << SH) + B64 - 64'd1) / B64);

    hash_state_t       state_reg, state_next;
    logic              round_reg, round_next;
    logic [63:0]       v_reg, v_next;
    logic [63:0]       acc_reg, acc_next;
    logic [KMER_W-1:0] kmer_reg, kmer_next;
    logic [RW-1:0]     rem_reg, rem_next;
    logic [QW-1:0]     quot_reg, quot_next;

    logic              m_valid_reg, m_valid_next;
    logic [KMER_W-1:0] m_kmer_reg, m_kmer_next;
    logic [IDX_W-1:0]  m_idx_reg, m_idx_next;

    logic [63:0]       mix_c;
    logic [31:0]       mul_a, mul_b;
    logic [63:0]       prod;
    logic [63:0]       partial;
    logic [63:0]       v_load;
    logic [FW-1:0]     fold_y;
    logic [ZW-1:0]     fold_z;
    logic [ZW+MW-1:0]  recip_prod;
    logic [ZW-1:0]     rem_full;
    logic [RW-1:0]     idx_raw;
    logic [RW+IDX_W-1:0] idx_ext;
    logic              out_free;

    assign m_valid          = m_valid_reg;
    assign m_canonical_kmer = m_kmer_reg;
    assign m_bucket_index   = m_idx_reg;
    assign out_free         = !m_valid_reg || m_ready;

    // Shared multiplier: operand halves chosen by the step
    assign mix_c = round_reg ? MIX_C2 : MIX_C1;
    always_comb begin
        case (state_reg)
            HS_MUL1: begin
                mul_a = v_reg[31:0];
                mul_b = mix_c[63:32];
            end
            HS_MUL2: begin
                mul_a = v_reg[63:32];
                mul_b = mix_c[31:0];
            end
            default: begin
                mul_a = v_reg[31:0];
                mul_b = mix_c[31:0];
            end
        endcase
    end
    assign prod    = mul_a * mul_b;
    assign partial = {acc_reg[63:32] + prod[31:0], acc_reg[31:0]};
    assign v_load  = {2'b00, q_rdata} ^ ({2'b00, q_rdata} >> 30);

    // Fold the hash, then the folded value, keeping the residue mod the bucket count
    assign fold_y = FW'(v_reg[63:48]) * FW'(R48) + FW'(v_reg[47:32]) * FW'(R32)
                  + FW'(v_reg[31:16]) * FW'(R16) + FW'(v_reg[15:0]);
    assign fold_z = ZW'(acc_reg[FW-1:16]) * ZW'(R16) + ZW'(acc_reg[15:0]);

    // Quotient by reciprocal, then subtract back to the remainder
    assign recip_prod = (ZW+MW)'(acc_reg[ZW-1:0]) * (ZW+MW)'(RECIP_M);
    assign rem_full   = acc_reg[ZW-1:0] - ZW'(quot_reg) * ZW'(BUCKETS);

    assign idx_raw = IS_POW2 ? (v_reg[RW-1:0] & LOW_MASK) : rem_reg;
    assign idx_ext = {{IDX_W{1'b0}}, idx_raw};

    // Sequencer: next state and datapath updates
    always_comb begin
        state_next   = state_reg;
        round_next   = round_reg;
        v_next       = v_reg;
        acc_next     = acc_reg;
        kmer_next    = kmer_reg;
        rem_next     = rem_reg;
        quot_next    = quot_reg;
        q_pop        = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        m_kmer_next  = m_kmer_reg;
        m_idx_next   = m_idx_reg;
        case (state_reg)
            HS_IDLE: begin
                if (!q_status.empty) begin
                    q_pop      = 1'b1;
                    kmer_next  = q_rdata;
                    v_next     = v_load;
                    round_next = 1'b0;
                    state_next = HS_MUL0;
                end
            end
            HS_MUL0: begin
                acc_next   = prod;
                state_next = HS_MUL1;
            end
            HS_MUL1: begin
                acc_next   = partial;
                state_next = HS_MUL2;
            end
            HS_MUL2: begin
                if (!round_reg) begin
                    v_next     = partial ^ (partial >> 27);
                    round_next = 1'b1;
                    state_next = HS_MUL0;
                end else begin
                    v_next     = partial ^ (partial >> 31);
                    state_next = IS_POW2 ? HS_DONE : HS_FOLD0;
                end
            end
            HS_FOLD0: begin
                acc_next   = 64'(fold_y);
                state_next = HS_FOLD1;
            end
            HS_FOLD1: begin
                acc_next   = 64'(fold_z);
                state_next = HS_RECIP;
            end
            HS_RECIP: begin
                quot_next  = recip_prod[ZW+MW-1:SH];
                state_next = HS_MOD;
            end
            HS_MOD: begin
                rem_next   = rem_full[RW-1:0];
                state_next = HS_DONE;
            end
            HS_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kmer_next  = kmer_reg;
                    m_idx_next   = idx_ext[IDX_W-1:0];
                    state_next   = HS_IDLE;
                end
            end
            default: state_next = HS_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= HS_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Hold datapath and output payload; no reset needed
    always_ff @(posedge aclk) begin
        round_reg  <= round_next;
        v_reg      <= v_next;
        acc_reg    <= acc_next;
        kmer_reg   <= kmer_next;
        rem_reg    <= rem_next;
        quot_reg   <= quot_next;
        m_kmer_reg <= m_kmer_next;
        m_idx_reg  <= m_idx_next;
    end

endmodule
`default_nettype wire

// ----- rtl/canonical_kmer_stream_bucketer.sv -----
// Each queued k-mer takes two hash rounds of three multiply steps, then, unless BUCKET_COUNT
//   is a power of two, two folds, a reciprocal multiply and a subtract for the remainder.
// Throughput: the front takes one character per cycle while the queue has room and no length
//   write is pending; the hash sequencer takes a new k-mer only once the last has left its
//   done state, and its single shared 32x32 multiplier does three partial products per round.
// Reset: synchronous active-low aresetn; k returns to 31, windows and run count clear.
`default_nettype none
module canonical_kmer_stream_bucketer #(
    parameter int BUCKET_COUNT = kcb_pkg::DEF_BUCKET_COUNT,
    parameter int QUEUE_DEPTH  = kcb_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [kcb_pkg::CHAR_W-1:0]    s_base_char,
    input  wire logic                          s_record_start,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [kcb_pkg::KMER_W-1:0]         m_canonical_kmer,
    output logic [kcb_pkg::IDX_W-1:0]          m_bucket_index,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [kcb_pkg::K_W-1:0]       cfg_kmer_length
);
    import kcb_pkg::*;

    queue_status_t     q_status;
    logic              q_push;
    logic              q_pop;
    logic [KMER_W-1:0] q_wdata;
    logic [KMER_W-1:0] q_rdata;

    kcb_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_base_char     (s_base_char),
        .s_record_start  (s_record_start),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_kmer_length (cfg_kmer_length),
        .q_status        (q_status),
        .q_push          (q_push),
        .q_wdata         (q_wdata)
    );

    kcb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_push   (q_push),
        .q_wdata  (q_wdata),
        .q_pop    (q_pop),
        .q_rdata  (q_rdata),
        .q_status (q_status)
    );

    kcb_hash #(
        .BUCKET_COUNT (BUCKET_COUNT)
    ) u_hash (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_status         (q_status),
        .q_rdata          (q_rdata),
        .q_pop            (q_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_canonical_kmer (m_canonical_kmer),
        .m_bucket_index   (m_bucket_index)
    );

    // Front never pushes a k-mer into a full queue
    assert property (@(posedge aclk) disable iff (!aresetn) q_push |-> !q_status.full)
        else $error("push into full queue");

    // Back end never pops an empty queue
    assert property (@(posedge aclk) disable iff (!aresetn) q_pop |-> !q_status.empty)
        else $error("pop from empty queue");

    // A push with no pop leaves work queued on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_push && !q_pop) |=> !q_status.empty)
        else $error("queued k-mer lost");

    // No result beat right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule
`default_nettype wire
